### rtl/rit_pkg.sv
// Shared types, codes and helpers for the radix integer text parser.
package rit_pkg;

    localparam int POS_BITS    = 16;
    localparam int IDX_BITS    = 16;
    localparam int QDEPTH      = 2;
    localparam int QPTR_BITS   = $clog2(QDEPTH);
    localparam int QCNT_BITS   = $clog2(QDEPTH + 1);
    localparam int CFG_IDX_BITS = 2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NULL     = 3'd1;
    localparam logic [2:0] ST_ILLEGAL  = 3'd2;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_NODIGITS = 3'd4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_RADIX  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SIGNED = 2'd1;

    localparam logic [5:0] RADIX_RESET = 6'd10;
    localparam logic [5:0] RADIX_MIN   = 6'd2;
    localparam logic [5:0] RADIX_MAX   = 6'd36;
    localparam logic [5:0] LETTER_BASE = 6'd10;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_word;

    typedef struct packed {
        logic [2:0]          status;
        logic [63:0]         value;
        logic [IDX_BITS-1:0] error_index;
    } t_out_word;

    typedef enum logic [1:0] {
        K_NULL,
        K_MINUS,
        K_DIGIT,
        K_ILLEGAL
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [5:0]          digit;
        logic [IDX_BITS-1:0] index;
        logic                last;
    } t_entry;

    typedef struct packed {
        logic [5:0] base;
        logic       signed_mode;
    } t_cfg;

    // Position as reported in error_index: low bits, optionally plus one.
    function automatic logic [IDX_BITS-1:0] pos_index(input logic [POS_BITS-1:0] pos,
                                                      input logic add_one);
        logic [POS_BITS+IDX_BITS-1:0] w;
        w = {{IDX_BITS{1'b0}}, pos} + {{(POS_BITS+IDX_BITS-1){1'b0}}, add_one};
        return w[IDX_BITS-1:0];
    endfunction

endpackage

### rtl/rit_front.sv
// Front end: character position tracking and character classification.
module rit_front import rit_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_take,
    input  t_in_word i_word,
    input  t_cfg     i_cfg,
    output t_entry   o_entry
);

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    logic [POS_BITS-1:0] r_pos;
    logic [POS_BITS-1:0] n_pos;
    logic [7:0]          w_ch;
    logic [7:0]          w_dv;
    logic                w_is_dig;

    assign w_ch = i_word.char_code;

    always_comb begin
        n_pos = r_pos;
        if (i_take) begin
            if (i_word.last_char) begin
                n_pos = '0;
            end else if (r_pos != POS_MAX) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    // Digit value of 0-9, A-Z, a-z; anything else is not a digit.
    always_comb begin
        w_dv     = 8'd0;
        w_is_dig = 1'b0;
        if (w_ch >= CH_ZERO && w_ch <= CH_NINE) begin
            w_dv     = w_ch - CH_ZERO;
            w_is_dig = 1'b1;
        end else if (w_ch >= CH_UP_A && w_ch <= CH_UP_Z) begin
            w_dv     = w_ch - CH_UP_A + {2'b00, LETTER_BASE};
            w_is_dig = 1'b1;
        end else if (w_ch >= CH_LO_A && w_ch <= CH_LO_Z) begin
            w_dv     = w_ch - CH_LO_A + {2'b00, LETTER_BASE};
            w_is_dig = 1'b1;
        end
    end

    always_comb begin
        o_entry.digit = w_dv[5:0];
        o_entry.last  = i_word.last_char;
        if (w_ch == CH_NUL) begin
            o_entry.kind  = K_NULL;
            o_entry.index = pos_index(r_pos, 1'b0);
        end else if (r_pos == '0 && i_cfg.signed_mode && w_ch == CH_MINUS) begin
            o_entry.kind  = K_MINUS;
            o_entry.index = '0;
        end else if (w_is_dig && w_dv[5:0] < i_cfg.base) begin
            o_entry.kind  = K_DIGIT;
            o_entry.index = '0;
        end else begin
            o_entry.kind  = K_ILLEGAL;
            o_entry.index = pos_index(r_pos, 1'b1);
        end
    end

endmodule

### rtl/rit_queue.sv
// Short queue of classified characters between front and back end.
module rit_queue import rit_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_data,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_empty,
    output t_entry o_data
);

    t_entry                r_mem [QDEPTH];
    logic [QPTR_BITS-1:0]  r_wp;
    logic [QPTR_BITS-1:0]  r_rp;
    logic [QCNT_BITS-1:0]  r_cnt;
    logic                  w_push;
    logic                  w_pop;

    assign o_full  = (r_cnt == QCNT_BITS'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### rtl/rit_back.sv
// Back end: accumulation, range checks, sticky error and result queue.
module rit_back import rit_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_q_empty,
    input  t_entry    i_q_data,
    output logic      o_q_pop,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_word o_word
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ACC  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    localparam logic [69:0] LIM_U64 = {6'b0, {64{1'b1}}};
    localparam logic [69:0] LIM_NEG = {6'b0, 1'b1, 63'b0};
    localparam logic [69:0] LIM_POS = {7'b0, {63{1'b1}}};

    t_state              r_state;
    t_state              n_state;
    logic [63:0]         r_acc;
    logic                r_neg;
    logic                r_seen;
    logic [2:0]          r_err;
    logic [IDX_BITS-1:0] r_err_idx;
    logic [69:0]         r_prod;
    t_entry              r_cur;

    t_out_word             r_oq [QDEPTH];
    logic [QPTR_BITS-1:0]  r_owp;
    logic [QPTR_BITS-1:0]  r_orp;
    logic [QCNT_BITS-1:0]  r_ocnt;

    logic        w_opush;
    logic        w_opop;
    logic [69:0] w_lim;
    logic [69:0] w_sum;
    t_out_word   w_res;

    assign o_empty = (r_ocnt == '0);
    assign o_word  = r_oq[r_orp];
    assign w_opop  = i_pop && !o_empty;
    assign w_opush = (r_state == S_EMIT) && (r_ocnt != QCNT_BITS'(QDEPTH));
    assign o_q_pop = (r_state == S_IDLE) && !i_q_empty;

    always_comb begin
        if (!i_cfg.signed_mode) begin
            w_lim = LIM_U64;
        end else if (r_neg) begin
            w_lim = LIM_NEG;
        end else begin
            w_lim = LIM_POS;
        end
    end

    assign w_sum = r_prod + {64'b0, r_cur.digit};

    // Build the result word from the literal state.
    always_comb begin
        w_res.status      = r_err;
        w_res.value       = 64'd0;
        w_res.error_index = '0;
        if (r_err == ST_OK && !r_seen) begin
            w_res.status = ST_NODIGITS;
        end
        if (r_err == ST_OK && r_seen) begin
            w_res.value = (i_cfg.signed_mode && r_neg) ? (64'd0 - r_acc) : r_acc;
        end
        if (r_err == ST_NULL || r_err == ST_ILLEGAL) begin
            w_res.error_index = r_err_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    if (r_err == ST_OK &&
                        (i_q_data.kind == K_DIGIT || i_q_data.kind == K_ILLEGAL)) begin
                        n_state = S_ACC;
                    end else if (i_q_data.last) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_ACC: begin
                n_state = r_cur.last ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (w_opush) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur  <= i_q_data;
            r_prod <= {6'b0, r_acc} * {64'b0, i_cfg.base};
        end
        if (w_opush) begin
            r_oq[r_owp] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_acc     <= '0;
            r_neg     <= 1'b0;
            r_seen    <= 1'b0;
            r_err     <= ST_OK;
            r_err_idx <= '0;
            r_owp     <= '0;
            r_orp     <= '0;
            r_ocnt    <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty && r_err == ST_OK) begin
                        if (i_q_data.kind == K_NULL) begin
                            r_err     <= ST_NULL;
                            r_err_idx <= i_q_data.index;
                        end else if (i_q_data.kind == K_MINUS) begin
                            r_neg <= 1'b1;
                        end
                    end
                end
                S_ACC: begin
                    // Overflow of the shift is checked before the digit itself.
                    if (r_prod > w_lim) begin
                        r_err     <= ST_RANGE;
                        r_err_idx <= '0;
                    end else if (r_cur.kind == K_ILLEGAL) begin
                        r_err     <= ST_ILLEGAL;
                        r_err_idx <= r_cur.index;
                    end else if (w_sum > w_lim) begin
                        r_err     <= ST_RANGE;
                        r_err_idx <= '0;
                    end else begin
                        r_acc  <= w_sum[63:0];
                        r_seen <= 1'b1;
                    end
                end
                S_EMIT: begin
                    if (w_opush) begin
                        r_acc     <= '0;
                        r_neg     <= 1'b0;
                        r_seen    <= 1'b0;
                        r_err     <= ST_OK;
                        r_err_idx <= '0;
                    end
                end
                default: begin
                    r_err <= r_err;
                end
            endcase
            if (w_opush) begin
                r_owp <= r_owp + 1'b1;
            end
            if (w_opop) begin
                r_orp <= r_orp + 1'b1;
            end
            if (w_opush && !w_opop) begin
                r_ocnt <= r_ocnt + 1'b1;
            end else if (w_opop && !w_opush) begin
                r_ocnt <= r_ocnt - 1'b1;
            end
        end
    end

endmodule

### rtl/radix_integer_text_parser.sv
// Radix integer text parser: top level with configuration registers.
//
// Parses an integer literal one character per input word and returns one
// result word when the word flagged last_char has been processed. Digits
// 0-9 and letters A-Z / a-z (case-insensitive, values 10 to 35) are taken
// in the configured radix (2 to 36; values outside are clamped). In signed
// mode a minus as the very first character negates the value, which must
// fit a signed 64-bit integer; in unsigned mode it must fit 64 bits. The
// first error of a literal sticks and later characters are ignored until
// the last one, which reports it: null character (error_index = position),
// illegal character (error_index = position plus one), out of range, or no
// digits. value is 0 whenever status is not ok.
//
// Structure: a front end classifies each word as it is pushed and places
// it in a two-entry queue; the back end works through that queue. A digit
// or illegal character goes through a registered 64 x 6 multiply as it is
// popped, then the range compares and the add in the accumulate state. A
// null, a minus or any character after an error is handled as it is
// popped. The last character of a literal then passes an emit state that
// writes the result into a two-entry result queue and waits while that
// queue is full, so words keep flowing in while results wait to be popped.
// The back end pops no new character until the digit path is done.
//
// Configuration: register 0 is radix (6 bits, reset 10), register 1 is
// signed_mode (1 bit, reset 1). Writes are always accepted; write only
// while no literal work is in flight.
module radix_integer_text_parser import rit_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  t_in_word                i_in_data,
    output logic                    empty,
    input  logic                    pop,
    output t_out_word               o_out_data,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [5:0]              i_cfg_data
);

    logic [5:0] r_radix;
    logic       r_signed;
    t_cfg       w_cfg;
    logic       w_take;
    t_entry     w_front_entry;
    logic       w_q_empty;
    logic       w_q_pop;
    t_entry     w_q_data;

    assign o_cfg_ready = 1'b1;

    // Hold the configuration registers; ignore indexes beyond the list.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= RADIX_RESET;
            r_signed <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RADIX:  r_radix  <= i_cfg_data;
                CFG_SIGNED: r_signed <= i_cfg_data[0];
                default:    r_radix  <= r_radix;
            endcase
        end
    end

    // Clamp the radix into the supported range.
    always_comb begin
        w_cfg.signed_mode = r_signed;
        if (r_radix < RADIX_MIN) begin
            w_cfg.base = RADIX_MIN;
        end else if (r_radix > RADIX_MAX) begin
            w_cfg.base = RADIX_MAX;
        end else begin
            w_cfg.base = r_radix;
        end
    end

    assign w_take = push && !full;

    rit_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_word  (i_in_data),
        .i_cfg   (w_cfg),
        .o_entry (w_front_entry)
    );

    rit_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_front_entry),
        .o_full  (full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_data  (w_q_data)
    );

    rit_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_q_empty (w_q_empty),
        .i_q_data  (w_q_data),
        .o_q_pop   (w_q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_word    (o_out_data)
    );

endmodule
